@@ rtl/hbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and fixed constants of the heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int HEIGHT_W   = 16;
  localparam int COORD_W    = 32;
  localparam int CHUNK_W    = 16;
  localparam int MAP_IDX_W  = 4;
  localparam int CELL_SHIFT = 10;
  localparam int FRAC_BITS  = 12;
  localparam int WEIGHT_W   = FRAC_BITS + 1;            // 0..4096
  localparam int PROD_W     = WEIGHT_W + 1 + HEIGHT_W;  // signed weight * height
  localparam int TERM_W     = PROD_W - FRAC_BITS;
  localparam int SUM_W      = TERM_W + 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WEIGHT_W-1:0] FIX_ONE = WEIGHT_W'(1 << FRAC_BITS);

  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 16'sh7FFF;
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 16'sh8000;

  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Y = 1'd1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Per-query info that travels beside the bank read data.
  typedef struct packed {
    logic                 outside;
    logic                 ty0;
    logic                 tx0;
    logic [FRAC_BITS-1:0] u;
    logic [FRAC_BITS-1:0] v;
  } frac_t;

endpackage

@@ rtl/hbs_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_in_if
// Input channel: map write or height query beat.
// ----------------------------------------------------------------------------
interface hbs_in_if;
  logic                                     valid;
  logic                                     ready;
  hbs_pkg::op_e                             operation;
  logic [hbs_pkg::MAP_IDX_W-1:0]            map_row;
  logic [hbs_pkg::MAP_IDX_W-1:0]            map_col;
  logic signed [hbs_pkg::HEIGHT_W-1:0]      height_value;
  logic signed [hbs_pkg::COORD_W-1:0]       world_x;
  logic signed [hbs_pkg::COORD_W-1:0]       world_y;

  modport source (
    output valid, operation, map_row, map_col, height_value, world_x, world_y,
    input  ready
  );
  modport sink (
    input  valid, operation, map_row, map_col, height_value, world_x, world_y,
    output ready
  );
endinterface

@@ rtl/hbs_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_out_if
// Output channel: interpolated height beat.
// ----------------------------------------------------------------------------
interface hbs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [hbs_pkg::HEIGHT_W-1:0] height;
  logic                                outside;

  modport source (output valid, height, outside, input ready);
  modport sink   (input  valid, height, outside, output ready);
endinterface

@@ rtl/hbs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 25,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hbs_addr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_addr
// Chunk-relative position, cell and weights, and bank addresses for the
// four corner reads and for map writes.
// ----------------------------------------------------------------------------
module hbs_addr #(
  parameter int CELLS_LOG2 = 3,
  localparam int SIDE        = (1 << CELLS_LOG2) + 1,
  localparam int BANK_SIDE   = (1 << (CELLS_LOG2 - 1)) + 1,
  localparam int BANK_DEPTH  = BANK_SIDE * BANK_SIDE,
  localparam int BA_W        = $clog2(BANK_DEPTH)
) (
  input  logic signed [hbs_pkg::CHUNK_W-1:0]   chunk_x_i,
  input  logic signed [hbs_pkg::CHUNK_W-1:0]   chunk_y_i,
  input  logic signed [hbs_pkg::COORD_W-1:0]   world_x_i,
  input  logic signed [hbs_pkg::COORD_W-1:0]   world_y_i,
  input  logic [hbs_pkg::MAP_IDX_W-1:0]        map_row_i,
  input  logic [hbs_pkg::MAP_IDX_W-1:0]        map_col_i,
  output logic [BA_W-1:0]                      raddr_o [4],
  output hbs_pkg::frac_t                       frac_o,
  output logic [BA_W-1:0]                      waddr_o,
  output logic [1:0]                           wbank_o,
  output logic                                 wr_ok_o
);
  import hbs_pkg::*;

  localparam int CHUNK_SHIFT = CELLS_LOG2 + CELL_SHIFT;
  localparam int CT_W        = CHUNK_W + CHUNK_SHIFT;
  localparam int DW          = ((CT_W > COORD_W) ? CT_W : COORD_W) + 1;
  localparam int UPAD        = FRAC_BITS - CELL_SHIFT;

  logic signed [DW-1:0]    xc, yc;
  logic [CELLS_LOG2-1:0]   tx, ty;
  logic [CELLS_LOG2:0]     rr [2];
  logic [CELLS_LOG2:0]     cc [2];
  logic                    in_x, in_y;

  always_comb begin
    xc = DW'(world_x_i) - (DW'(chunk_x_i) <<< CHUNK_SHIFT);
    yc = DW'(world_y_i) - (DW'(chunk_y_i) <<< CHUNK_SHIFT);
    in_x = (xc[DW-1:CHUNK_SHIFT] == '0);
    in_y = (yc[DW-1:CHUNK_SHIFT] == '0);
    tx = xc[CHUNK_SHIFT-1:CELL_SHIFT];
    ty = yc[CHUNK_SHIFT-1:CELL_SHIFT];

    frac_o.outside = !(in_x && in_y);
    frac_o.tx0     = tx[0];
    frac_o.ty0     = ty[0];
    frac_o.u       = {xc[CELL_SHIFT-1:0], {UPAD{1'b0}}};
    frac_o.v       = {yc[CELL_SHIFT-1:0], {UPAD{1'b0}}};

    // Row/column of the given parity among {t, t+1}.
    for (int p = 0; p < 2; p++) begin
      rr[p] = {1'b0, ty} + (CELLS_LOG2 + 1)'(p[0] ^ ty[0]);
      cc[p] = {1'b0, tx} + (CELLS_LOG2 + 1)'(p[0] ^ tx[0]);
    end
    // Bank index is {row parity, column parity}.
    for (int b = 0; b < 4; b++) begin
      raddr_o[b] = BA_W'(rr[b >> 1][CELLS_LOG2:1]) * BA_W'(BANK_SIDE)
                 + BA_W'(cc[b & 1][CELLS_LOG2:1]);
    end

    wr_ok_o = (int'(map_row_i) < SIDE) && (int'(map_col_i) < SIDE);
    wbank_o = {map_row_i[0], map_col_i[0]};
    waddr_o = BA_W'(map_row_i[MAP_IDX_W-1:1]) * BA_W'(BANK_SIDE)
            + BA_W'(map_col_i[MAP_IDX_W-1:1]);
  end

endmodule

@@ rtl/hbs_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbs_blend
// Weight products, weighted heights and saturating sum, three registered
// stages after the bank read stage, all advancing on one enable.
// ----------------------------------------------------------------------------
module hbs_blend (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  hbs_pkg::frac_t                       frac_i,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0]  bank_i [4],
  output logic                                 valid_o,
  output logic signed [hbs_pkg::HEIGHT_W-1:0]  height_o,
  output logic                                 outside_o
);
  import hbs_pkg::*;

  // read stage (aligned with RAM output)
  logic  v1_q;
  frac_t f1_q;

  // weight stage
  logic                       v2_q, out2_q;
  logic [WEIGHT_W-1:0]        w2_q [4];
  logic signed [HEIGHT_W-1:0] h2_q [4];
  logic [WEIGHT_W-1:0]        ui, vi, uc, vc;
  logic [2*WEIGHT_W-1:0]      wp [4];
  logic [1:0]                 corner [4];

  // product stage
  logic                       v3_q, out3_q;
  logic signed [TERM_W-1:0]   t3_q [4];
  logic signed [PROD_W-1:0]   pp [4];

  // output stage
  logic                       v4_q, out4_q;
  logic signed [HEIGHT_W-1:0] h4_q;
  logic signed [SUM_W-1:0]    sum;
  logic signed [HEIGHT_W-1:0] h4_d;

  always_comb begin
    ui = {1'b0, f1_q.u};
    vi = {1'b0, f1_q.v};
    uc = FIX_ONE - ui;
    vc = FIX_ONE - vi;
    wp[0] = uc * vc;   // (ty,   tx)
    wp[1] = ui * vc;   // (ty,   tx+1)
    wp[2] = ui * vi;   // (ty+1, tx+1)
    wp[3] = uc * vi;   // (ty+1, tx)
    corner[0] = { f1_q.ty0,  f1_q.tx0};
    corner[1] = { f1_q.ty0, ~f1_q.tx0};
    corner[2] = {~f1_q.ty0, ~f1_q.tx0};
    corner[3] = {~f1_q.ty0,  f1_q.tx0};

    for (int i = 0; i < 4; i++) begin
      pp[i] = $signed({1'b0, w2_q[i]}) * h2_q[i];
    end

    sum = SUM_W'(t3_q[0]) + SUM_W'(t3_q[1]) + SUM_W'(t3_q[2]) + SUM_W'(t3_q[3]);
    if (out3_q) begin
      h4_d = '0;
    end else if (sum > SUM_W'(HEIGHT_MAX)) begin
      h4_d = HEIGHT_MAX;
    end else if (sum < SUM_W'(HEIGHT_MIN)) begin
      h4_d = HEIGHT_MIN;
    end else begin
      h4_d = HEIGHT_W'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q   <= frac_i;
      out2_q <= f1_q.outside;
      out3_q <= out2_q;
      out4_q <= out3_q;
      h4_q   <= h4_d;
      for (int i = 0; i < 4; i++) begin
        w2_q[i] <= wp[i][FRAC_BITS +: WEIGHT_W];
        h2_q[i] <= bank_i[corner[i]];
        t3_q[i] <= pp[i][PROD_W-1:FRAC_BITS];
      end
    end
  end

  assign valid_o   = v4_q;
  assign height_o  = h4_q;
  assign outside_o = out4_q;

endmodule

@@ rtl/heightmap_bilinear_sampler_unit.sv @@
// A query's result is registered through the RAM read, weight, product and sum stages.
// Throughput: one beat per cycle, writes and queries freely mixed; a stalled
// output holds the whole 4-stage pipeline (RAM read, weights, products, sum).
// Reset: chunk_x/chunk_y clear to 0 and the pipeline empties; heightmap
// contents are undefined until written (no clearing pass).
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_unit
// Bilinear height lookup over one terrain chunk held in four parity banks.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_unit #(
  parameter int CELLS_LOG2 = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  hbs_in_if.sink                            in_if,
  hbs_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hbs_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import hbs_pkg::*;

  // The (SIDE x SIDE) map is split by row and column parity into four banks.
  // The four corners of any cell always have distinct parity pairs, so each
  // bank serves exactly one corner per query: four reads in the same cycle.
  localparam int BANK_SIDE  = (1 << (CELLS_LOG2 - 1)) + 1;
  localparam int BANK_DEPTH = BANK_SIDE * BANK_SIDE;
  localparam int BA_W       = $clog2(BANK_DEPTH);

  logic signed [CHUNK_W-1:0] chunk_x_q, chunk_y_q;

  logic                       en;
  logic                       accept;
  logic                       wr_ok;
  logic [1:0]                 wbank;
  logic [BA_W-1:0]            waddr;
  logic [BA_W-1:0]            raddr [4];
  logic [HEIGHT_W-1:0]        rdata [4];
  logic signed [HEIGHT_W-1:0] bank_h [4];
  frac_t                      frac;
  logic                       out_valid;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_x_q <= '0;
      chunk_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHUNK_X: chunk_x_q <= $signed(cfg_wdata_i);
        CFG_CHUNK_Y: chunk_y_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // ---- handshake ----
  // The whole pipeline moves together; it only halts when the output
  // register holds a beat the sink has not taken.
  assign en           = !out_valid || out_if.ready;
  assign in_if.ready  = en;
  assign accept       = in_if.valid && en;

  // ---- address generation ----
  hbs_addr #(
    .CELLS_LOG2 (CELLS_LOG2)
  ) u_addr (
    .chunk_x_i (chunk_x_q),
    .chunk_y_i (chunk_y_q),
    .world_x_i (in_if.world_x),
    .world_y_i (in_if.world_y),
    .map_row_i (in_if.map_row),
    .map_col_i (in_if.map_col),
    .raddr_o   (raddr),
    .frac_o    (frac),
    .waddr_o   (waddr),
    .wbank_o   (wbank),
    .wr_ok_o   (wr_ok)
  );

  // ---- map banks ----
  // Writes land at the accepting edge, so a query in the very next beat
  // already reads the new value; an item is never both a write and a read.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic we;
    assign we = accept && (in_if.operation == OP_WRITE) && wr_ok
             && (wbank == 2'(b));

    hbs_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (in_if.height_value),
      .re_i    (en),
      .raddr_i (raddr[b]),
      .rdata_o (rdata[b])
    );

    assign bank_h[b] = $signed(rdata[b]);
  end

  // ---- blend pipeline ----
  hbs_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_if.valid && (in_if.operation == OP_QUERY)),
    .frac_i    (frac),
    .bank_i    (bank_h),
    .valid_o   (out_valid),
    .height_o  (out_if.height),
    .outside_o (out_if.outside)
  );

  assign out_if.valid = out_valid;

endmodule

@@ bench/heightmap_bilinear_sampler_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_unit_tb
// Self-checking bench for the bilinear heightmap sampler. Preloads the whole
// grid, runs directed corner/edge beats, then mixed random writes and queries
// under several chunk origins. A local model predicts every query result;
// results are checked in order against it.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_unit_tb;
  import hbs_pkg::*;

  // Grid geometry for the default build.
  localparam int      CELLS_LOG2   = 3;
  localparam int      SIDE         = (1 << CELLS_LOG2) + 1;
  localparam longint  CELL_LEN     = 64'd1 << CELL_SHIFT;
  localparam longint  CHUNK_SPAN   = 64'd1 << (CELLS_LOG2 + CELL_SHIFT);
  localparam longint  UNIT         = 64'd1 << FRAC_BITS;
  // Pipeline is 4 stages deep; give it a few extra cycles to go quiet.
  localparam int      SETTLE_CYCLES = 8;
  localparam int      REPORT_LIMIT  = 10;

  typedef struct packed {
    op_e                         op;
    logic [MAP_IDX_W-1:0]        row;
    logic [MAP_IDX_W-1:0]        col;
    logic signed [HEIGHT_W-1:0]  hv;
    logic signed [COORD_W-1:0]   wx;
    logic signed [COORD_W-1:0]   wy;
  } map_beat_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0]  height;
    logic                        outside;
  } height_result_t;

  // Receiver stall patterns.
  typedef enum int {
    RX_STEADY,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hbs_in_if  in_ch ();
  hbs_out_if out_ch ();

  heightmap_bilinear_sampler_unit #(
    .CELLS_LOG2 (CELLS_LOG2)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Local copy of the block's state: grid contents and chunk origin.
  logic signed [HEIGHT_W-1:0] height_grid [SIDE][SIDE];
  logic signed [CHUNK_W-1:0]  chunk_x_cfg;
  logic signed [CHUNK_W-1:0]  chunk_y_cfg;

  map_beat_t      beat_queue [$];     // beats waiting for the driver
  height_result_t height_expect_q [$]; // predicted heights, oldest first
  int             fail_count;
  logic           in_taken;           // a beat was accepted at the last rising edge

  // Sender burst/gap counters and receiver pattern state.
  int       burst_left;
  int       gap_left;
  rx_mode_e rx_mode;
  int       rx_left;
  int       rx_phase;

  // --------------------------------------------------------------------------
  // Height predictor
  // --------------------------------------------------------------------------
  // One weighted corner: weight * height, then floor divide by 4096.
  function automatic longint weigh(input longint w, input logic signed [HEIGHT_W-1:0] h);
    return (w * longint'(h)) >>> FRAC_BITS;
  endfunction

  function automatic height_result_t sample_height(input logic signed [COORD_W-1:0] wx,
                                                   input logic signed [COORD_W-1:0] wy);
    height_result_t res;
    longint xc, yc, u, v, acc;
    int     tx, ty;
    xc = longint'(wx) - longint'(chunk_x_cfg) * CHUNK_SPAN;
    yc = longint'(wy) - longint'(chunk_y_cfg) * CHUNK_SPAN;
    // Anything off the chunk on either axis reads as zero with the flag set.
    if (xc < 0 || yc < 0 || xc >= CHUNK_SPAN || yc >= CHUNK_SPAN) begin
      res.height  = '0;
      res.outside = 1'b1;
      return res;
    end
    tx = int'(xc >>> CELL_SHIFT);
    ty = int'(yc >>> CELL_SHIFT);
    u  = ((xc & (CELL_LEN - 1)) << FRAC_BITS) >>> CELL_SHIFT;
    v  = ((yc & (CELL_LEN - 1)) << FRAC_BITS) >>> CELL_SHIFT;
    // Weight products are non-negative; each is floored before it meets a height.
    acc = weigh(((UNIT - u) * (UNIT - v)) >>> FRAC_BITS, height_grid[ty][tx])
        + weigh((u * (UNIT - v)) >>> FRAC_BITS,          height_grid[ty][tx + 1])
        + weigh((u * v) >>> FRAC_BITS,                   height_grid[ty + 1][tx + 1])
        + weigh(((UNIT - u) * v) >>> FRAC_BITS,          height_grid[ty + 1][tx]);
    if (acc > 32767)  acc = 32767;
    if (acc < -32768) acc = -32768;
    res.height  = HEIGHT_W'(acc);
    res.outside = 1'b0;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic push_write(input int row, input int col, input logic signed [15:0] hv);
    map_beat_t b;
    b.op  = OP_WRITE;
    b.row = MAP_IDX_W'(row);
    b.col = MAP_IDX_W'(col);
    b.hv  = hv;
    // Query-only fields ride along with junk; the block must ignore them.
    b.wx  = COORD_W'($urandom);
    b.wy  = COORD_W'($urandom);
    beat_queue.push_back(b);
  endtask

  task automatic push_query(input logic signed [COORD_W-1:0] wx,
                            input logic signed [COORD_W-1:0] wy);
    map_beat_t b;
    b.op  = OP_QUERY;
    b.row = MAP_IDX_W'($urandom);
    b.col = MAP_IDX_W'($urandom);
    b.hv  = HEIGHT_W'($urandom);
    b.wx  = wx;
    b.wy  = wy;
    beat_queue.push_back(b);
  endtask

  function automatic logic signed [15:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return $urandom_range(0, 1) ? 16'sh0000 : 16'shFFFF;
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  // One axis of a query position, biased toward the held chunk.
  function automatic logic signed [COORD_W-1:0] pick_coord(input logic signed [CHUNK_W-1:0] chunk);
    longint origin;
    int     r;
    origin = longint'(chunk) * CHUNK_SPAN;
    r = $urandom_range(0, 99);
    if (r < 70)
      return COORD_W'(origin + $urandom_range(0, int'(CHUNK_SPAN) - 1));
    if (r < 80)   // cell corners and last offset in a cell
      return COORD_W'(origin + $urandom_range(0, SIDE - 2) * CELL_LEN +
                      ($urandom_range(0, 1) ? CELL_LEN - 1 : 0));
    if (r < 90) begin   // just inside / just outside the chunk edges
      case ($urandom_range(0, 5))
        0:       return COORD_W'(origin - 1);
        1:       return COORD_W'(origin - 2);
        2:       return COORD_W'(origin);
        3:       return COORD_W'(origin + CHUNK_SPAN - 1);
        4:       return COORD_W'(origin + CHUNK_SPAN);
        default: return COORD_W'(origin + CHUNK_SPAN + 1);
      endcase
    end
    return COORD_W'($urandom);
  endfunction

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        // Mostly real grid updates, some out-of-range rows/cols that are dropped.
        if ($urandom_range(0, 9) == 0)
          push_write($urandom_range(0, 15), $urandom_range(0, 15), pick_height());
        else
          push_write($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1), pick_height());
      end else begin
        push_query(pick_coord(chunk_x_cfg), pick_coord(chunk_y_cfg));
      end
    end
  endtask

  // Wait until every queued beat is taken and every result has come back.
  task automatic wait_idle();
    while (beat_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (height_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    if (idx == CFG_CHUNK_X) chunk_x_cfg = data;
    else                    chunk_y_cfg = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_chunk(input logic [15:0] cx, input logic [15:0] cy);
    write_reg(CFG_CHUNK_X, cx);
    write_reg(CFG_CHUNK_Y, cy);
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    map_beat_t b;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (beat_queue.size() != 0) begin
        b = beat_queue.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= b.op;
        in_ch.map_row      <= b.row;
        in_ch.map_col      <= b.col;
        in_ch.height_value <= b.hv;
        in_ch.world_x      <= b.wx;
        in_ch.world_y      <= b.wy;
        if (burst_left <= 1) begin
          // Long bursts now and then give stretches with no sender idling.
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows a pattern that is redrawn at random cycles
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 150);
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        RX_STEADY: out_ch.ready <= 1'b1;
        RX_LIGHT:  out_ch.ready <= ($urandom_range(0, 9) < 7);
        RX_HEAVY:  out_ch.ready <= ($urandom_range(0, 9) < 2);
        default:   out_ch.ready <= ((rx_phase % 8) < 5);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: track accepted input beats, check result beats in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    height_result_t want;
    height_result_t got;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.height  = out_ch.height;
        got.outside = out_ch.outside;
        if (height_expect_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: unexpected result beat height=%0d outside=%0b",
                     $realtime, got.height, got.outside);
          fail_count++;
        end else begin
          want = height_expect_q.pop_front();
          if (got.height !== want.height || got.outside !== want.outside) begin
            if (fail_count < REPORT_LIMIT)
              $display("%0t: mismatch height exp=%0d got=%0d  outside exp=%0b got=%0b",
                       $realtime, want.height, got.height, want.outside, got.outside);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_WRITE) begin
          // Rows/cols past the grid edge are dropped by the block.
          if (in_ch.map_row < SIDE && in_ch.map_col < SIDE)
            height_grid[in_ch.map_row][in_ch.map_col] = in_ch.height_value;
        end else begin
          height_expect_q.push_back(sample_height(in_ch.world_x, in_ch.world_y));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Run sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_WRITE;
    in_ch.map_row      = '0;
    in_ch.map_col      = '0;
    in_ch.height_value = '0;
    in_ch.world_x      = '0;
    in_ch.world_y      = '0;
    out_ch.ready       = 1'b0;
    chunk_x_cfg        = '0;
    chunk_y_cfg        = '0;
    fail_count         = 0;
    in_taken           = 1'b0;
    burst_left         = 0;
    gap_left           = 0;
    rx_mode            = RX_STEADY;
    rx_left            = 0;
    rx_phase           = 0;
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++)
        height_grid[r][c] = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    set_chunk(16'd0, 16'd0);

    // Grid contents are undefined after reset, so every entry is loaded
    // before the first query can touch it.
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++)
        push_write(r, c, pick_height());

    // Directed: height extremes, dropped writes, cell/chunk corners, edges.
    push_write(0, 0, 16'sh7FFF);
    push_write(SIDE - 1, SIDE - 1, 16'sh8000);
    push_write(15, 3, 16'sh1234);        // row off the grid
    push_write(2, SIDE, 16'sh4321);      // column off the grid
    push_write(SIDE, 15, 16'shFFFF);     // both off
    push_query(32'sd0, 32'sd0);
    push_query(32'sd8191, 32'sd8191);
    push_query(32'sd1023, 32'sd0);
    push_query(32'sd8191, 32'sd0);
    push_query(32'sd0, 32'sd8191);
    push_query(32'sd4608, 32'sd4608);
    push_query(-32'sd1, 32'sd0);
    push_query(32'sd0, -32'sd1);
    push_query(32'sd8192, 32'sd0);
    push_query(32'sd0, 32'sd8192);
    push_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    push_query(32'sh8000_0000, 32'sh8000_0000);
    push_write(4, 4, 16'shFFFF);
    push_query(32'sd4096, 32'sd4096);    // read right behind the write
    push_write(4, 5, 16'sh8000);
    push_write(5, 4, 16'sh7FFF);
    push_query(32'sd4097, 32'sd4097);
    push_query(32'sd2048, 32'sd3072);
    wait_idle();

    push_random(100);
    wait_idle();

    // Extreme chunk origins.
    set_chunk(16'h8000, 16'h7FFF);
    push_query(32'shF000_0000, 32'sh0FFF_E000);  // both chunk origins exactly
    push_random(70);
    wait_idle();

    set_chunk(16'h7FFF, 16'h8000);
    push_random(50);
    wait_idle();

    // Random origin; sender holds off midway until all results are back.
    set_chunk(16'($urandom), 16'($urandom));
    push_random(35);
    wait_idle();
    push_random(35);

    while (beat_queue.size() != 0 || in_ch.valid || height_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += height_expect_q.size();

    if (fail_count == 0)
      $display("** heightmap_bilinear_sampler_unit: PASSED **");
    else
      $display("** heightmap_bilinear_sampler_unit: FAILED **");
    $finish;
  end

  // Hard stop: far beyond the slowest legal run (~400 beats, each with a
  // worst-case gap and receiver stall).
  initial begin
    #2_000_000;
    $display("** heightmap_bilinear_sampler_unit: FAILED **");
    $finish;
  end

endmodule
